/* hw/rtl/pgv_pkg.sv */
// Shared types and constants of the pixel gradient and vignette block.
// Holds the configuration register layout, its indexes and reset values.
// Depends on nothing; every other file imports it.
`default_nettype none

package pgv_pkg;

    // Payload widths of the pixel stream.
    localparam int PIX_W   = 8;
    localparam int COORD_W = 12;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_GRADIENT_AMP      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VIG_GAIN          = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAD_COS          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAD_SIN          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_DIAGONAL      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_RADIUS_NORM   = 3'd7;

    // Register values after reset.
    localparam logic [15:0]        RST_GRADIENT_AMP      = 16'd0;
    localparam logic [15:0]        RST_VIG_GAIN          = 16'd0;
    localparam logic signed [15:0] RST_GRAD_COS          = 16'sd16384;
    localparam logic signed [15:0] RST_GRAD_SIN          = 16'sd0;
    localparam logic [12:0]        RST_FRAME_WIDTH       = 13'd640;
    localparam logic [12:0]        RST_FRAME_HEIGHT      = 13'd480;
    localparam logic [23:0]        RST_INV_DIAGONAL      = 24'd20972;
    localparam logic [39:0]        RST_INV_RADIUS_NORM   = 40'd1832519;

    // The full set of configuration registers.
    typedef struct packed {
        logic [15:0]        gradient_amp;
        logic [15:0]        vig_gain;
        logic signed [15:0] grad_cos;
        logic signed [15:0] grad_sin;
        logic [12:0]        frame_width;
        logic [12:0]        frame_height;
        logic [23:0]        inv_diagonal;
        logic [39:0]        inv_radius_norm;
    } t_cfg;

endpackage

`default_nettype wire

/* hw/rtl/pgv_in_if.sv */
// Input pixel channel: valid/ready handshake with pixel and coordinates.
// Depends on pgv_pkg for the payload widths.
`default_nettype none

interface pgv_in_if;
    import pgv_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIX_W-1:0]   pixel_in;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row_index;
    logic               frame_end;

    modport source (output valid, output pixel_in, output col, output row_index,
                    output frame_end, input ready);
    modport sink   (input valid, input pixel_in, input col, input row_index,
                    input frame_end, output ready);
endinterface

`default_nettype wire

/* hw/rtl/pgv_out_if.sv */
// Output pixel channel: valid/ready handshake with the processed pixel.
// Depends on pgv_pkg for the payload widths.
`default_nettype none

interface pgv_out_if;
    import pgv_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_out;
    logic             frame_end_out;

    modport source (output valid, output pixel_out, output frame_end_out, input ready);
    modport sink   (input valid, input pixel_out, input frame_end_out, output ready);
endinterface

`default_nettype wire

/* hw/rtl/pgv_cfg_regs.sv */
// Configuration register file of the pixel gradient and vignette block.
// Depends on pgv_pkg for the register layout, indexes and reset values.
`default_nettype none

module pgv_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_we,
    input  wire logic [pgv_pkg::CFG_IDX_W-1:0]  i_idx,
    input  wire logic [pgv_pkg::CFG_DATA_W-1:0] i_data,
    output pgv_pkg::t_cfg                       o_cfg
);
    import pgv_pkg::*;

    t_cfg r_cfg;

    // Each write loads the low bits of the data into the addressed register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gradient_amp      <= RST_GRADIENT_AMP;
            r_cfg.vig_gain          <= RST_VIG_GAIN;
            r_cfg.grad_cos          <= RST_GRAD_COS;
            r_cfg.grad_sin          <= RST_GRAD_SIN;
            r_cfg.frame_width       <= RST_FRAME_WIDTH;
            r_cfg.frame_height      <= RST_FRAME_HEIGHT;
            r_cfg.inv_diagonal      <= RST_INV_DIAGONAL;
            r_cfg.inv_radius_norm   <= RST_INV_RADIUS_NORM;
        end else if (i_we) begin
            case (i_idx)
                CFG_GRADIENT_AMP:      r_cfg.gradient_amp      <= i_data[15:0];
                CFG_VIG_GAIN:          r_cfg.vig_gain          <= i_data[15:0];
                CFG_GRAD_COS:          r_cfg.grad_cos          <= i_data[15:0];
                CFG_GRAD_SIN:          r_cfg.grad_sin          <= i_data[15:0];
                CFG_FRAME_WIDTH:       r_cfg.frame_width       <= i_data[12:0];
                CFG_FRAME_HEIGHT:      r_cfg.frame_height      <= i_data[12:0];
                CFG_INV_DIAGONAL:      r_cfg.inv_diagonal      <= i_data[23:0];
                CFG_INV_RADIUS_NORM:   r_cfg.inv_radius_norm   <= i_data[39:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* hw/rtl/pixel_gradient_vignette.sv */
// Pixel gradient and vignette: a twelve-stage pipeline, one item per clock while the output
// is ready; the depth is set by the chain of multipliers (gradient, radius, strength, product).
// Each stage holds its item while the next one is full, so bubbles close up
// and an item is still taken while a finished result waits at the output.
// Synchronous reset empties the pipeline and loads the register defaults.
`default_nettype none

module pixel_gradient_vignette (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [pgv_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [pgv_pkg::CFG_DATA_W-1:0] i_cfg_data,
    pgv_in_if.sink                              i_pix,
    pgv_out_if.source                           o_pix
);
    import pgv_pkg::*;

    localparam int          NSTG  = 12;
    localparam logic [59:0] F_ONE = 60'h0_0001_0000_0000;
    localparam logic [47:0] HALF  = 48'h8000_0000_0000;

    t_cfg cfg;

    pgv_cfg_regs u_cfg (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_we   (i_cfg_we),
        .i_idx  (i_cfg_idx),
        .i_data (i_cfg_data),
        .o_cfg  (cfg)
    );

    // ---------------------------------------------------------------
    // Flow control: a stage loads when it is empty or its item moves on.
    // ---------------------------------------------------------------
    logic [NSTG:1] r_vld;
    logic [NSTG:1] w_en;
    logic [NSTG:1] r_fe;

    always_comb begin
        w_en[NSTG] = !r_vld[NSTG] || o_pix.ready;
        for (int k = NSTG - 1; k >= 1; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[1]) begin
                r_vld[1] <= i_pix.valid;
            end
            for (int k = 2; k <= NSTG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Frame-end marker rides along with its item.
    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_fe[1] <= i_pix.frame_end;
        end
        for (int k = 2; k <= NSTG; k++) begin
            if (w_en[k]) begin
                r_fe[k] <= r_fe[k-1];
            end
        end
    end

    assign i_pix.ready = w_en[1];

    // ---------------------------------------------------------------
    // Stage 1: direction products and centered offsets.
    // ---------------------------------------------------------------
    logic signed [28:0] n_s1_pc, n_s1_ps;
    logic signed [13:0] n_s1_dx, n_s1_dy;
    logic signed [27:0] r_s1_pc, r_s1_ps;
    logic signed [13:0] r_s1_dx, r_s1_dy;
    logic [PIX_W-1:0]   r_s1_pix;

    assign n_s1_pc = $signed({1'b0, i_pix.col}) * $signed(cfg.grad_cos);
    assign n_s1_ps = $signed({1'b0, i_pix.row_index}) * $signed(cfg.grad_sin);
    assign n_s1_dx = $signed({1'b0, i_pix.col, 1'b0}) - $signed({1'b0, cfg.frame_width});
    assign n_s1_dy = $signed({1'b0, i_pix.row_index, 1'b0})
                   - $signed({1'b0, cfg.frame_height});

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_s1_pc  <= n_s1_pc[27:0];
            r_s1_ps  <= n_s1_ps[27:0];
            r_s1_dx  <= n_s1_dx;
            r_s1_dy  <= n_s1_dy;
            r_s1_pix <= i_pix.pixel_in;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: gradient projection magnitude and squared offsets.
    // ---------------------------------------------------------------
    logic signed [28:0] n_s2_sum;
    logic [28:0]        n_s2_mag;
    logic signed [27:0] n_s2_dxx, n_s2_dyy;
    logic [27:0]        r_s2_ms;
    logic               r_s2_sneg;
    logic [25:0]        r_s2_dxx, r_s2_dyy;
    logic [PIX_W-1:0]   r_s2_pix;

    assign n_s2_sum = 29'(r_s1_pc) + 29'(r_s1_ps);
    assign n_s2_mag = n_s2_sum[28] ? -n_s2_sum : n_s2_sum;
    assign n_s2_dxx = r_s1_dx * r_s1_dx;
    assign n_s2_dyy = r_s1_dy * r_s1_dy;

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_s2_ms   <= n_s2_mag[27:0];
            r_s2_sneg <= n_s2_sum[28];
            r_s2_dxx  <= n_s2_dxx[25:0];
            r_s2_dyy  <= n_s2_dyy[25:0];
            r_s2_pix  <= r_s1_pix;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: projection over the diagonal; squared radius.
    // ---------------------------------------------------------------
    logic [51:0]      n_s3_m1;
    logic [26:0]      n_s3_d;
    logic [51:0]      r_s3_m1;
    logic [26:0]      r_s3_d;
    logic             r_s3_sneg;
    logic [PIX_W-1:0] r_s3_pix;

    assign n_s3_m1 = r_s2_ms * cfg.inv_diagonal;
    assign n_s3_d  = 27'(r_s2_dxx) + 27'(r_s2_dyy);

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_s3_m1   <= n_s3_m1;
            r_s3_d    <= n_s3_d;
            r_s3_sneg <= r_s2_sneg;
            r_s3_pix  <= r_s2_pix;
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: gradient amplitude; radius normalization in two halves.
    // ---------------------------------------------------------------
    logic [51:0]      n_s4_m2;
    logic [46:0]      n_s4_a, n_s4_b;
    logic [51:0]      r_s4_m2;
    logic [46:0]      r_s4_a, r_s4_b;
    logic             r_s4_sneg;
    logic [PIX_W-1:0] r_s4_pix;

    assign n_s4_m2 = r_s3_m1[51:16] * cfg.gradient_amp;
    assign n_s4_a  = r_s3_d * cfg.inv_radius_norm[39:20];
    assign n_s4_b  = r_s3_d * cfg.inv_radius_norm[19:0];

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r_s4_m2   <= n_s4_m2;
            r_s4_a    <= n_s4_a;
            r_s4_b    <= n_s4_b;
            r_s4_sneg <= r_s3_sneg;
            r_s4_pix  <= r_s3_pix;
        end
    end

    // ---------------------------------------------------------------
    // Stage 5: signed pixel plus gradient as sign and magnitude; r2.
    // ---------------------------------------------------------------
    logic [37:0] n_s5_g;
    logic [38:0] n_s5_pix16, n_s5_add, n_s5_pmg, n_s5_mv;
    logic [39:0] n_s5_gmp;
    logic        n_s5_gt;
    logic [66:0] n_s5_sum;
    logic [38:0] r_s5_mv;
    logic        r_s5_vneg;
    logic [42:0] r_s5_r2;

    assign n_s5_g     = r_s4_m2[51:14];
    assign n_s5_pix16 = {15'd0, r_s4_pix, 16'd0};
    assign n_s5_add   = n_s5_pix16 + {1'b0, n_s5_g};
    assign n_s5_gmp   = {2'b00, n_s5_g} - {1'b0, n_s5_pix16};
    assign n_s5_pmg   = n_s5_pix16 - {1'b0, n_s5_g};
    assign n_s5_gt    = {1'b0, n_s5_g} > n_s5_pix16;

    // A negative gradient larger than the pixel turns the value negative.
    always_comb begin
        if (!r_s4_sneg) begin
            n_s5_mv = n_s5_add;
        end else if (n_s5_gt) begin
            n_s5_mv = n_s5_gmp[38:0];
        end else begin
            n_s5_mv = n_s5_pmg;
        end
    end

    assign n_s5_sum = {r_s4_a, 20'd0} + 67'(r_s4_b);

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r_s5_mv   <= n_s5_mv;
            r_s5_vneg <= r_s4_sneg && n_s5_gt;
            r_s5_r2   <= n_s5_sum[66:24];
        end
    end

    // ---------------------------------------------------------------
    // Stage 6: strength times r2, split over the width of r2.
    // ---------------------------------------------------------------
    logic [37:0] n_s6_ph;
    logic [36:0] n_s6_pl;
    logic [37:0] r_s6_ph;
    logic [36:0] r_s6_pl;
    logic [38:0] r_s6_mv;
    logic        r_s6_vneg;

    assign n_s6_ph = cfg.vig_gain * r_s5_r2[42:21];
    assign n_s6_pl = cfg.vig_gain * r_s5_r2[20:0];

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r_s6_ph   <= n_s6_ph;
            r_s6_pl   <= n_s6_pl;
            r_s6_mv   <= r_s5_mv;
            r_s6_vneg <= r_s5_vneg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 7: recombine strength times r2.
    // ---------------------------------------------------------------
    logic [58:0] n_s7_sr;
    logic [58:0] r_s7_sr;
    logic [38:0] r_s7_mv;
    logic        r_s7_vneg;

    assign n_s7_sr = {r_s6_ph, 21'd0} + 59'(r_s6_pl);

    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            r_s7_sr   <= n_s7_sr;
            r_s7_mv   <= r_s6_mv;
            r_s7_vneg <= r_s6_vneg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 8: vignette factor 1 - strength*r2 as sign and magnitude,
    // and the sign of the product.
    // ---------------------------------------------------------------
    logic [59:0] n_s8_fa, n_s8_fb;
    logic        n_s8_fzero, n_s8_fneg;
    logic [58:0] r_s8_mf;
    logic [38:0] r_s8_mv;
    logic        r_s8_pos;

    assign n_s8_fa    = {1'b0, r_s7_sr} - F_ONE;
    assign n_s8_fb    = F_ONE - {1'b0, r_s7_sr};
    assign n_s8_fzero = (r_s7_sr == F_ONE[58:0]);
    assign n_s8_fneg  = !n_s8_fa[59] && !n_s8_fzero;

    // Only a nonzero product with matching signs gives a nonzero pixel.
    always_ff @(posedge i_clk) begin
        if (w_en[8]) begin
            r_s8_mf  <= n_s8_fneg ? n_s8_fa[58:0] : n_s8_fb[58:0];
            r_s8_mv  <= r_s7_mv;
            r_s8_pos <= (r_s7_mv != '0) && !n_s8_fzero && (r_s7_vneg == n_s8_fneg);
        end
    end

    // ---------------------------------------------------------------
    // Stage 9: four partial products of value times factor.
    // ---------------------------------------------------------------
    logic [49:0] n_s9_hh;
    logic [48:0] n_s9_hl, n_s9_lh;
    logic [47:0] n_s9_ll;
    logic [49:0] r_s9_hh;
    logic [48:0] r_s9_hl, r_s9_lh;
    logic [47:0] r_s9_ll;
    logic        r_s9_pos;

    assign n_s9_hh = r_s8_mv[38:19] * r_s8_mf[58:29];
    assign n_s9_hl = r_s8_mv[38:19] * r_s8_mf[28:0];
    assign n_s9_lh = r_s8_mv[18:0] * r_s8_mf[58:29];
    assign n_s9_ll = r_s8_mv[18:0] * r_s8_mf[28:0];

    always_ff @(posedge i_clk) begin
        if (w_en[9]) begin
            r_s9_hh  <= n_s9_hh;
            r_s9_hl  <= n_s9_hl;
            r_s9_lh  <= n_s9_lh;
            r_s9_ll  <= n_s9_ll;
            r_s9_pos <= r_s8_pos;
        end
    end

    // ---------------------------------------------------------------
    // Stage 10: value times upper and lower factor halves.
    // ---------------------------------------------------------------
    logic [68:0] n_s10_phi;
    logic [67:0] n_s10_plo;
    logic [68:0] r_s10_phi;
    logic [67:0] r_s10_plo;
    logic        r_s10_pos;

    assign n_s10_phi = {r_s9_hh, 19'd0} + 69'(r_s9_lh);
    assign n_s10_plo = {r_s9_hl, 19'd0} + 68'(r_s9_ll);

    always_ff @(posedge i_clk) begin
        if (w_en[10]) begin
            r_s10_phi <= n_s10_phi;
            r_s10_plo <= n_s10_plo;
            r_s10_pos <= r_s9_pos;
        end
    end

    // ---------------------------------------------------------------
    // Stage 11: full product, split into integer part and fraction.
    // ---------------------------------------------------------------
    logic [97:0]      n_s11_p;
    logic             r_s11_sat;
    logic [PIX_W-1:0] r_s11_q;
    logic [47:0]      r_s11_frac;
    logic             r_s11_pos;

    assign n_s11_p = {r_s10_phi, 29'd0} + 98'(r_s10_plo);

    always_ff @(posedge i_clk) begin
        if (w_en[11]) begin
            r_s11_sat  <= (n_s11_p[97:56] != '0);
            r_s11_q    <= n_s11_p[55:48];
            r_s11_frac <= n_s11_p[47:0];
            r_s11_pos  <= r_s10_pos;
        end
    end

    // ---------------------------------------------------------------
    // Stage 12: round half to even, clamp, output register.
    // ---------------------------------------------------------------
    logic             n_s12_up;
    logic [PIX_W:0]   n_s12_qr;
    logic [PIX_W-1:0] n_s12_pix;
    logic [PIX_W-1:0] r_s12_pix;

    assign n_s12_up = (r_s11_frac > HALF) || ((r_s11_frac == HALF) && r_s11_q[0]);
    assign n_s12_qr = {1'b0, r_s11_q} + (PIX_W + 1)'(n_s12_up);

    always_comb begin
        if (!r_s11_pos) begin
            n_s12_pix = '0;
        end else if (r_s11_sat || n_s12_qr[PIX_W]) begin
            n_s12_pix = '1;
        end else begin
            n_s12_pix = n_s12_qr[PIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[12]) begin
            r_s12_pix <= n_s12_pix;
        end
    end

    assign o_pix.valid         = r_vld[NSTG];
    assign o_pix.pixel_out     = r_s12_pix;
    assign o_pix.frame_end_out = r_fe[NSTG];

endmodule

`default_nettype wire

/* tb/tb_pixel_gradient_vignette.sv */
`timescale 1ns / 1ps
// Self-checking bench for pixel_gradient_vignette: gradient, vignette, rounding and clamping.
// Depends on pgv_pkg, pgv_in_if, pgv_out_if and the block itself; an internal scoreboard predicts.

module tb_pixel_gradient_vignette;
    import pgv_pkg::*;

    localparam int RUN_LIMIT    = 200000;
    localparam int DRAIN_CYCLES = 24;
    localparam int PHASE_COUNT  = 10;
    localparam int PHASE_ITEMS  = 103;
    localparam int HOLD_PERIOD  = 120;
    localparam int HOLD_CYCLES  = 100;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_end;
    } t_pixel_result;

    // Scoreboard: keeps a copy of the registers, predicts each pixel and checks the outputs.
    class pixel_scoreboard;
        t_cfg          cfg;
        t_pixel_result expected_q[$];
        int unsigned   mismatches;

        function new();
            mismatches = 0;
            cfg.gradient_amp      = RST_GRADIENT_AMP;
            cfg.vig_gain          = RST_VIG_GAIN;
            cfg.grad_cos          = RST_GRAD_COS;
            cfg.grad_sin          = RST_GRAD_SIN;
            cfg.frame_width       = RST_FRAME_WIDTH;
            cfg.frame_height      = RST_FRAME_HEIGHT;
            cfg.inv_diagonal      = RST_INV_DIAGONAL;
            cfg.inv_radius_norm   = RST_INV_RADIUS_NORM;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_GRADIENT_AMP:      cfg.gradient_amp      = data[15:0];
                CFG_VIG_GAIN:          cfg.vig_gain          = data[15:0];
                CFG_GRAD_COS:          cfg.grad_cos          = data[15:0];
                CFG_GRAD_SIN:          cfg.grad_sin          = data[15:0];
                CFG_FRAME_WIDTH:       cfg.frame_width       = data[12:0];
                CFG_FRAME_HEIGHT:      cfg.frame_height      = data[12:0];
                CFG_INV_DIAGONAL:      cfg.inv_diagonal      = data[23:0];
                CFG_INV_RADIUS_NORM:   cfg.inv_radius_norm   = data[39:0];
                default: ;
            endcase
        endfunction

        // Fixed-point pixel path: signed gradient, Q.32 vignette factor, Q.48 product.
        function t_pixel_result predict_pixel(logic [PIX_W-1:0] pix, logic [COORD_W-1:0] x_u,
                                              logic [COORD_W-1:0] y_u, logic fe);
            longint            x, y, s, v, f, dx, dy;
            longint unsigned   ms, g, d, a, b, r2, sr, mv, mf, p, q, frac;
            logic              neg;
            t_pixel_result     r;
            x = {52'd0, x_u};
            y = {52'd0, y_u};

            // Gradient term, truncated toward zero and carrying the sign of s.
            s  = x * longint'($signed(cfg.grad_cos)) + y * longint'($signed(cfg.grad_sin));
            ms = (s < 0) ? -s : s;
            g  = (((ms * cfg.inv_diagonal) >> 16) * cfg.gradient_amp) >> 14;
            v  = (longint'(pix) << 16) + ((s < 0) ? -longint'(g) : longint'(g));

            // Vignette factor from the squared normalized radius.
            dx = 2 * x - longint'(cfg.frame_width);
            dy = 2 * y - longint'(cfg.frame_height);
            d  = dx * dx + dy * dy;
            a  = d * (cfg.inv_radius_norm >> 20);
            b  = d * (cfg.inv_radius_norm & 40'hF_FFFF);
            r2 = (a >> 4) + ((((a & 64'd15) << 20) + b) >> 24);
            sr = cfg.vig_gain * r2;
            f  = 64'sh1_0000_0000 - longint'(sr);

            // Product with saturation, round half to even, clamp.
            mv  = (v < 0) ? -v : v;
            mf  = (f < 0) ? -f : f;
            neg = (v < 0) != (f < 0);
            if (mv == 0 || mf == 0 || neg) begin
                q = 0;
            end else if (mf > 64'h7FFF_FFFF_FFFF_FFFF / mv) begin
                q = 255;
            end else begin
                p    = mv * mf;
                q    = p >> 48;
                frac = p & 64'hFFFF_FFFF_FFFF;
                if (frac > 64'h8000_0000_0000 || (frac == 64'h8000_0000_0000 && q[0])) begin
                    q++;
                end
                if (q > 255) begin
                    q = 255;
                end
            end
            r.pixel     = q[7:0];
            r.frame_end = fe;
            return r;
        endfunction

        function void note_pixel(logic [PIX_W-1:0] pix, logic [COORD_W-1:0] x_u,
                                 logic [COORD_W-1:0] y_u, logic fe);
            expected_q.push_back(predict_pixel(pix, x_u, y_u, fe));
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_pixel(logic [PIX_W-1:0] pixel, logic frame_end);
            t_pixel_result exp_r;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected item: pixel %0d frame_end %0b",
                                          pixel, frame_end));
                return;
            end
            exp_r = expected_q.pop_front();
            if (pixel !== exp_r.pixel) begin
                report_mismatch($sformatf("pixel_out %0d, predicted %0d", pixel, exp_r.pixel));
            end
            if (frame_end !== exp_r.frame_end) begin
                report_mismatch($sformatf("frame_end_out %0b, predicted %0b",
                                          frame_end, exp_r.frame_end));
            end
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    pgv_in_if  pix_in ();
    pgv_out_if pix_out ();

    pixel_scoreboard sb;
    int unsigned     cycle_cnt      = 0;
    int unsigned     src_idle_pct   = 0;
    int unsigned     sink_stall_pct = 0;
    bit              sink_hold      = 1'b0;

    pixel_gradient_vignette dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_in),
        .o_pix      (pix_out)
    );

    // Clock, 12 ns period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Cycle counter and the run limit.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    initial begin
        wait (cycle_cnt >= RUN_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // Receiver: random stalls, or long hold-offs that back the pipeline up into the input.
    initial begin
        int unsigned hold_phase;
        hold_phase = 0;
        pix_out.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (sink_hold) begin
                hold_phase = (hold_phase + 1) % HOLD_PERIOD;
                pix_out.ready <= (hold_phase >= HOLD_CYCLES);
            end else begin
                pix_out.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
            end
        end
    end

    // Accepted input items feed the prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && pix_in.valid && pix_in.ready) begin
            sb.note_pixel(pix_in.pixel_in, pix_in.col, pix_in.row_index, pix_in.frame_end);
        end
    end

    // Accepted output items are checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && pix_out.valid && pix_out.ready) begin
            sb.check_pixel(pix_out.pixel_out, pix_out.frame_end_out);
        end
    end

    // One register write; called at a rising edge, returns at the capturing edge.
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        sb.write_reg(idx, data);
        @(posedge i_clk);
    endtask

    task automatic write_regs(t_cfg c);
        cfg_write(CFG_GRADIENT_AMP,      {24'd0, c.gradient_amp});
        cfg_write(CFG_VIG_GAIN,          {24'd0, c.vig_gain});
        cfg_write(CFG_GRAD_COS,          {24'd0, c.grad_cos});
        cfg_write(CFG_GRAD_SIN,          {24'd0, c.grad_sin});
        cfg_write(CFG_FRAME_WIDTH,       {27'd0, c.frame_width});
        cfg_write(CFG_FRAME_HEIGHT,      {27'd0, c.frame_height});
        cfg_write(CFG_INV_DIAGONAL,      {16'd0, c.inv_diagonal});
        cfg_write(CFG_INV_RADIUS_NORM,   c.inv_radius_norm);
        i_cfg_we <= 1'b0;
    endtask

    // Offers one item after random idle cycles and returns at the edge that accepts it.
    task automatic send_pixel(logic [PIX_W-1:0] pix, logic [COORD_W-1:0] x,
                              logic [COORD_W-1:0] y, logic fe);
        while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
            pix_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_in.valid     <= 1'b1;
        pix_in.pixel_in  <= pix;
        pix_in.col       <= x;
        pix_in.row_index <= y;
        pix_in.frame_end <= fe;
        @(posedge i_clk);
        while (!pix_in.ready) begin
            @(posedge i_clk);
        end
    endtask

    // Stops offering and waits until every predicted item has come out.
    task automatic drain_pipeline();
        pix_in.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Registers matching a real frame size, with a random direction, amplitude and strength.
    function automatic t_cfg make_scene_cfg(int unsigned w, int unsigned h);
        t_cfg            c;
        real             theta;
        longint unsigned norm;
        norm  = longint'(w * w + h * h);
        theta = real'($urandom_range(0, 3599)) * 3.14159265358979 / 1800.0;
        c.gradient_amp      = $urandom_range(0, 1) ? 16'($urandom_range(0, 16'h3FFF))
                                                   : 16'($urandom_range(0, 16'hFFFF));
        c.vig_gain          = 16'($urandom_range(0, 16'hFFFF));
        c.grad_cos          = 16'($rtoi($cos(theta) * 16384.0));
        c.grad_sin          = 16'($rtoi($sin(theta) * 16384.0));
        c.frame_width       = 13'(w);
        c.frame_height      = 13'(h);
        c.inv_diagonal      = 24'($rtoi(16777216.0 / $sqrt(real'(norm))));
        c.inv_radius_norm   = 40'((64'd1 << 40) / norm);
        return c;
    endfunction

    // Mostly raster runs through the frame, with jumps inside it and anywhere in range.
    task automatic run_random_phase(int unsigned n_items, t_cfg c);
        int unsigned      x, y, wlim, hlim, roll;
        logic [PIX_W-1:0] pix;
        logic             fe;
        wlim = (c.frame_width == 0) ? 1 : ((c.frame_width > 4096) ? 4096 : c.frame_width);
        hlim = (c.frame_height == 0) ? 1 : ((c.frame_height > 4096) ? 4096 : c.frame_height);
        x = $urandom_range(0, wlim - 1);
        y = $urandom_range(0, hlim - 1);
        repeat (n_items) begin
            roll = $urandom_range(0, 99);
            if (roll < 12) begin
                x = $urandom_range(0, 4095);
                y = $urandom_range(0, 4095);
            end else if (roll < 25) begin
                x = $urandom_range(0, wlim - 1);
                y = $urandom_range(0, hlim - 1);
            end else begin
                x++;
                if (x >= wlim) begin
                    x = 0;
                    y++;
                    if (y >= hlim) begin
                        y = 0;
                    end
                end
            end
            fe   = (x == wlim - 1 && y == hlim - 1) || ($urandom_range(0, 15) == 0);
            roll = $urandom_range(0, 9);
            pix  = (roll == 0) ? 8'd0 : ((roll == 1) ? 8'd255 : 8'($urandom_range(0, 255)));
            send_pixel(pix, 12'(x), 12'(y), fe);
        end
    endtask

    // Main sequence: reset, directed corner cases, then random phases.
    initial begin
        int unsigned k;
        t_cfg        c;
        sb = new();
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = '0;
        i_cfg_data       = '0;
        pix_in.valid     = 1'b0;
        pix_in.pixel_in  = '0;
        pix_in.col       = '0;
        pix_in.row_index = '0;
        pix_in.frame_end = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Values after reset pass the pixel through unchanged.
        send_pixel(8'd0, 12'd0, 12'd0, 1'b0);
        send_pixel(8'd255, 12'd4095, 12'd4095, 1'b1);
        send_pixel(8'd128, 12'd639, 12'd479, 1'b0);
        send_pixel(8'd1, 12'd320, 12'd240, 1'b1);
        drain_pipeline();

        // Huge positive gradient: the product overflows and saturates high.
        c = '{gradient_amp: 16'hFFFF, vig_gain: 16'd0, grad_cos: 16'sd16384,
              grad_sin: 16'sd16384, frame_width: 13'd640, frame_height: 13'd480,
              inv_diagonal: 24'hFF_FFFF, inv_radius_norm: 40'd1832519};
        write_regs(c);
        send_pixel(8'd200, 12'd4095, 12'd4095, 1'b0);
        send_pixel(8'd0, 12'd0, 12'd0, 1'b1);
        send_pixel(8'd255, 12'd1, 12'd0, 1'b0);
        send_pixel(8'd17, 12'd4095, 12'd0, 1'b0);
        drain_pipeline();

        // Direction and frame size beyond their stated ranges: negative pixel goes to zero.
        c = '{gradient_amp: 16'hFFFF, vig_gain: 16'd0, grad_cos: 16'sh8000,
              grad_sin: -16'sd16384, frame_width: 13'd8191, frame_height: 13'd8191,
              inv_diagonal: 24'hFF_FFFF, inv_radius_norm: 40'hFF_FFFF_FFFF};
        write_regs(c);
        send_pixel(8'd255, 12'd4095, 12'd4095, 1'b0);
        send_pixel(8'd255, 12'd0, 12'd0, 1'b0);
        send_pixel(8'd90, 12'd1, 12'd1, 1'b1);
        drain_pipeline();

        // Zero frame size and zero inverse diagonal; strong vignette makes the factor negative.
        c = '{gradient_amp: 16'd0, vig_gain: 16'hFFFF, grad_cos: 16'sd16384,
              grad_sin: 16'sd0, frame_width: 13'd0, frame_height: 13'd0,
              inv_diagonal: 24'd0, inv_radius_norm: 40'hFF_FFFF_FFFF};
        write_regs(c);
        send_pixel(8'd77, 12'd0, 12'd0, 1'b0);
        send_pixel(8'd77, 12'd1, 12'd0, 1'b0);
        send_pixel(8'd255, 12'd4095, 12'd4095, 1'b1);
        send_pixel(8'd3, 12'd0, 12'd1, 1'b0);
        drain_pipeline();

        // Negative pixel times negative factor: positive overflow saturates high.
        c = '{gradient_amp: 16'hFFFF, vig_gain: 16'hFFFF, grad_cos: -16'sd16384,
              grad_sin: -16'sd16384, frame_width: 13'd0, frame_height: 13'd0,
              inv_diagonal: 24'hFF_FFFF, inv_radius_norm: 40'hFF_FFFF_FFFF};
        write_regs(c);
        send_pixel(8'd0, 12'd4095, 12'd4095, 1'b1);
        send_pixel(8'd255, 12'd4095, 12'd0, 1'b0);
        send_pixel(8'd100, 12'd2048, 12'd2048, 1'b0);
        drain_pipeline();

        // Small frame with coordinates far outside it.
        c = make_scene_cfg(16, 16);
        write_regs(c);
        send_pixel(8'd128, 12'd4095, 12'd0, 1'b0);
        send_pixel(8'd128, 12'd0, 12'd4095, 1'b1);
        send_pixel(8'd128, 12'd15, 12'd15, 1'b0);
        send_pixel(8'd255, 12'd8, 12'd8, 1'b0);
        drain_pipeline();

        // Random phases over several register settings and flow patterns.
        for (k = 0; k < PHASE_COUNT; k++) begin
            case (k)
                3: c = '{gradient_amp: 16'hFFFF, vig_gain: 16'hFFFF,
                         grad_cos: 16'sd16384, grad_sin: 16'sd16384,
                         frame_width: 13'd4096, frame_height: 13'd4096,
                         inv_diagonal: 24'hFF_FFFF, inv_radius_norm: 40'h80_0000_0000};
                5: c = '{gradient_amp: 16'd0, vig_gain: 16'd0,
                         grad_cos: -16'sd16384, grad_sin: -16'sd16384,
                         frame_width: 13'd1, frame_height: 13'd1,
                         inv_diagonal: 24'd0, inv_radius_norm: 40'd0};
                7: c = '{gradient_amp: 16'($urandom), vig_gain: 16'($urandom),
                         grad_cos: 16'($urandom), grad_sin: 16'($urandom),
                         frame_width: 13'($urandom), frame_height: 13'($urandom),
                         inv_diagonal: 24'($urandom),
                         inv_radius_norm: {8'($urandom), 32'($urandom)}};
                default: begin
                    if (k % 2 == 1) begin
                        c = make_scene_cfg($urandom_range(16, 4096), $urandom_range(16, 4096));
                    end else begin
                        c = make_scene_cfg($urandom_range(16, 64), $urandom_range(16, 64));
                    end
                end
            endcase
            write_regs(c);
            case (k % 5)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  sink_hold = 1'b0; end
                1: begin src_idle_pct = 75; sink_stall_pct = 0;  sink_hold = 1'b0; end
                2: begin src_idle_pct = 0;  sink_stall_pct = 75; sink_hold = 1'b0; end
                3: begin src_idle_pct = 29; sink_stall_pct = 29; sink_hold = 1'b0; end
                default: begin src_idle_pct = 0; sink_stall_pct = 0; sink_hold = 1'b1; end
            endcase
            run_random_phase(PHASE_ITEMS, c);
            drain_pipeline();
        end

        // Let any stray item show up before the verdict.
        sink_hold      = 1'b0;
        sink_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* pixel_gradient_vignette.f */
hw/rtl/pgv_pkg.sv
hw/rtl/pgv_in_if.sv
hw/rtl/pgv_out_if.sv
hw/rtl/pgv_cfg_regs.sv
hw/rtl/pixel_gradient_vignette.sv
tb/tb_pixel_gradient_vignette.sv
